>>> sv/ghal_pkg.sv
package ghal_pkg;

	localparam int DEF_SLOT_COUNT = 256;
	localparam int DEF_GEN_BITS   = 16;

	localparam int OP_W     = 2;
	localparam int TEX_W    = 14;
	localparam int FMT_W    = 8;
	localparam int STATUS_W = 3;

	localparam logic [OP_W-1:0] OP_CREATE  = 2'd0;
	localparam logic [OP_W-1:0] OP_DESTROY = 2'd1;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 3'd0,
		ST_BAD_EXTENT = 3'd1,
		ST_BAD_FORMAT = 3'd2,
		ST_FULL       = 3'd3,
		ST_NOT_FOUND  = 3'd4
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_EXEC = 1'b1
	} fsm_state_t;

	typedef struct packed {
		logic capture;
		logic commit;
	} ghal_cmd_t;

endpackage

>>> sv/ghal_ctrl.sv
module ghal_ctrl
	import ghal_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  logic      out_stall,
	output ghal_cmd_t cmd
);

	fsm_state_t state_q, state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_EXEC;
			end
			S_EXEC: begin
				if (out_free) state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		in_stall    = 1'b1;
		cmd.capture = 1'b0;
		cmd.commit  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_stall    = 1'b0;
				cmd.capture = in_valid;
			end
			S_EXEC: begin
				cmd.commit = out_free;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	// a captured word always gets its result word
	a_capture_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> (in_stall && state_q == S_EXEC))
		else $error("capture did not enter exec");

	a_commit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid)
		else $error("commit did not raise out_valid");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |-> !cmd.commit)
		else $error("result overwritten while stalled");

endmodule

>>> sv/ghal_dp.sv
module ghal_dp
	import ghal_pkg::*;
#(
	parameter int SLOT_COUNT = DEF_SLOT_COUNT,
	parameter int GEN_BITS   = DEF_GEN_BITS,
	localparam int IDX_W     = $clog2(SLOT_COUNT),
	localparam int CNT_W     = $clog2(SLOT_COUNT + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ghal_cmd_t           cmd,
	input  logic [OP_W-1:0]     op,
	input  logic [IDX_W-1:0]    handle_index,
	input  logic [GEN_BITS-1:0] handle_generation,
	input  logic [TEX_W-1:0]    tex_width,
	input  logic [TEX_W-1:0]    tex_height,
	input  logic [FMT_W-1:0]    tex_format,
	output logic [STATUS_W-1:0] status,
	output logic [IDX_W-1:0]    out_index,
	output logic [GEN_BITS-1:0] out_generation,
	output logic [TEX_W-1:0]    out_width,
	output logic [TEX_W-1:0]    out_height,
	output logic [FMT_W-1:0]    out_format,
	output logic [CNT_W-1:0]    live_count
);

	typedef struct packed {
		logic [GEN_BITS-1:0] gen;
		logic [TEX_W-1:0]    w;
		logic [TEX_W-1:0]    h;
		logic [FMT_W-1:0]    f;
	} slot_t;

	typedef struct packed {
		logic [IDX_W-1:0]    idx;
		logic [GEN_BITS-1:0] gen;
	} stack_t;

	slot_t  slot_mem  [SLOT_COUNT];
	stack_t stack_mem [SLOT_COUNT];

	slot_t  slot_rd_q;
	stack_t stack_rd_q;

	logic [OP_W-1:0]     op_q;
	logic [IDX_W-1:0]    idx_q;
	logic [GEN_BITS-1:0] gen_q;
	logic [TEX_W-1:0]    w_q, h_q;
	logic [FMT_W-1:0]    f_q;

	logic [SLOT_COUNT-1:0] occ_q;
	logic [CNT_W-1:0]      free_q, used_q, live_q;
	logic [CNT_W-1:0]      free_d, used_d, live_d;
	logic [CNT_W-1:0]      stack_top;

	status_t             res_status;
	logic [IDX_W-1:0]    res_idx;
	logic [GEN_BITS-1:0] res_gen;
	logic [TEX_W-1:0]    res_w, res_h;
	logic [FMT_W-1:0]    res_f;

	status_t             status_q;
	logic [IDX_W-1:0]    out_index_q;
	logic [GEN_BITS-1:0] out_gen_q;
	logic [TEX_W-1:0]    out_w_q, out_h_q;
	logic [FMT_W-1:0]    out_f_q;
	logic [CNT_W-1:0]    live_out_q;

	logic                match;
	logic [GEN_BITS-1:0] g_inc, g_next;
	logic                slot_we, stack_we, occ_set, occ_clr;
	logic [IDX_W-1:0]    wr_idx;
	slot_t               slot_wd;
	stack_t              stack_wd;

	assign stack_top = free_q - CNT_W'(1);
	assign match     = (CNT_W'(idx_q) < used_q) && occ_q[idx_q] && (slot_rd_q.gen == gen_q);
	assign g_inc     = slot_rd_q.gen + GEN_BITS'(1);
	assign g_next    = (g_inc == '0) ? GEN_BITS'(1) : g_inc;

	always_comb begin
		res_status = ST_OK;
		res_idx    = '0;
		res_gen    = '0;
		res_w      = '0;
		res_h      = '0;
		res_f      = '0;
		slot_we    = 1'b0;
		stack_we   = 1'b0;
		occ_set    = 1'b0;
		occ_clr    = 1'b0;
		wr_idx     = idx_q;
		slot_wd    = '0;
		stack_wd   = '0;
		free_d     = free_q;
		used_d     = used_q;
		live_d     = live_q;
		priority if (op_q == OP_CREATE) begin
			priority if (w_q == '0 || h_q == '0) begin
				res_status = ST_BAD_EXTENT;
			end else if (f_q == '0) begin
				res_status = ST_BAD_FORMAT;
			end else if (free_q != '0) begin
				wr_idx     = stack_rd_q.idx;
				slot_wd    = '{gen: stack_rd_q.gen, w: w_q, h: h_q, f: f_q};
				free_d     = stack_top;
				slot_we    = 1'b1;
			end else if (used_q < CNT_W'(SLOT_COUNT)) begin
				wr_idx     = used_q[IDX_W-1:0];
				slot_wd    = '{gen: GEN_BITS'(1), w: w_q, h: h_q, f: f_q};
				used_d     = used_q + CNT_W'(1);
				slot_we    = 1'b1;
			end else begin
				res_status = ST_FULL;
			end
			if (slot_we) begin
				occ_set = 1'b1;
				live_d  = live_q + CNT_W'(1);
				res_idx = wr_idx;
				res_gen = slot_wd.gen;
			end
		end else if (op_q == OP_DESTROY) begin
			if (!match) begin
				res_status = ST_NOT_FOUND;
			end else begin
				slot_we = 1'b1;
				slot_wd = '{gen: g_next, w: '0, h: '0, f: '0};
				occ_clr = 1'b1;
				if (free_q < CNT_W'(SLOT_COUNT)) begin
					stack_we = 1'b1;
					stack_wd = '{idx: idx_q, gen: g_next};
					free_d   = free_q + CNT_W'(1);
				end
				if (live_q != '0) live_d = live_q - CNT_W'(1);
			end
		end else begin
			if (!match) begin
				res_status = ST_NOT_FOUND;
			end else begin
				res_w = slot_rd_q.w;
				res_h = slot_rd_q.h;
				res_f = slot_rd_q.f;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			slot_rd_q  <= slot_mem[handle_index];
			stack_rd_q <= stack_mem[stack_top[IDX_W-1:0]];
			op_q       <= op;
			idx_q      <= handle_index;
			gen_q      <= handle_generation;
			w_q        <= tex_width;
			h_q        <= tex_height;
			f_q        <= tex_format;
		end
		if (cmd.commit && slot_we) slot_mem[wr_idx] <= slot_wd;
		if (cmd.commit && stack_we) stack_mem[free_q[IDX_W-1:0]] <= stack_wd;
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status_q    <= res_status;
			out_index_q <= res_idx;
			out_gen_q   <= res_gen;
			out_w_q     <= res_w;
			out_h_q     <= res_h;
			out_f_q     <= res_f;
			live_out_q  <= live_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q  <= '0;
			free_q <= '0;
			used_q <= '0;
			live_q <= '0;
		end else if (cmd.commit) begin
			free_q <= free_d;
			used_q <= used_d;
			live_q <= live_d;
			if (occ_set) occ_q[wr_idx] <= 1'b1;
			else if (occ_clr) occ_q[wr_idx] <= 1'b0;
		end
	end

	assign status         = status_q;
	assign out_index      = out_index_q;
	assign out_generation = out_gen_q;
	assign out_width      = out_w_q;
	assign out_height     = out_h_q;
	assign out_format     = out_f_q;
	assign live_count     = live_out_q;

	// every used slot is either live or on the free stack
	a_slot_balance: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, live_q} + {1'b0, free_q}) == {1'b0, used_q})
		else $error("live plus free differs from used");

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CNT_W'(SLOT_COUNT))
		else $error("used count beyond capacity");

	a_create_live: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && occ_set) |=> (live_q == $past(live_q) + CNT_W'(1)))
		else $error("create did not bump live count");

endmodule

>>> sv/generational_handle_allocator_unit.sv
// Generational handle allocator: a slot table that hands out (index, generation)
// handles for texture descriptors.
// Input channel: in_valid / in_stall with op, handle_index, handle_generation,
// tex_width, tex_height, tex_format; a word is taken when in_valid is high and
// in_stall is low. Op create allocates a slot, destroy frees it, lookup returns
// the stored descriptor.
// Output channel: out_valid / out_stall with status, out_index, out_generation,
// out_width, out_height, out_format and live_count; one result word per input
// word, in order.
// The input word is captured into the operand registers together with the slot and
// free-stack memory reads; the result is registered when the execute step commits,
// which waits only while a stalled result occupies the output. No new input word is
// taken until the current one has committed, as the reads are followed by write-back.
// A stalled result holds; the next input word is still taken, and its result
// waits in the execute step until the output register frees up.
// Reset clears the live/used/free counters and the occupancy bits; the slot and
// stack memories need no clearing, so words are taken right after reset.
module generational_handle_allocator_unit
	import ghal_pkg::*;
#(
	parameter int SLOT_COUNT = DEF_SLOT_COUNT,
	parameter int GEN_BITS   = DEF_GEN_BITS,
	localparam int IDX_W     = $clog2(SLOT_COUNT),
	localparam int CNT_W     = $clog2(SLOT_COUNT + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [OP_W-1:0]     op,
	input  logic [IDX_W-1:0]    handle_index,
	input  logic [GEN_BITS-1:0] handle_generation,
	input  logic [TEX_W-1:0]    tex_width,
	input  logic [TEX_W-1:0]    tex_height,
	input  logic [FMT_W-1:0]    tex_format,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [STATUS_W-1:0] status,
	output logic [IDX_W-1:0]    out_index,
	output logic [GEN_BITS-1:0] out_generation,
	output logic [TEX_W-1:0]    out_width,
	output logic [TEX_W-1:0]    out_height,
	output logic [FMT_W-1:0]    out_format,
	output logic [CNT_W-1:0]    live_count
);

	ghal_cmd_t cmd;

	ghal_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	ghal_dp #(
		.SLOT_COUNT (SLOT_COUNT),
		.GEN_BITS   (GEN_BITS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.op                (op),
		.handle_index      (handle_index),
		.handle_generation (handle_generation),
		.tex_width         (tex_width),
		.tex_height        (tex_height),
		.tex_format        (tex_format),
		.status            (status),
		.out_index         (out_index),
		.out_generation    (out_generation),
		.out_width         (out_width),
		.out_height        (out_height),
		.out_format        (out_format),
		.live_count        (live_count)
	);

endmodule
